FILE: src/accel_calibrated_magnitude_smoother_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calibrated magnitude smoother
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ACCEL_CALIBRATED_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH
`define ACCEL_CALIBRATED_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACMS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ACMS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acms assertion failed");

`endif

FILE: src/acms_pkg.sv
// ----------------------------------------------------------------------------
// acms_pkg
// Widths, constants and the controller/datapath interface types of the
// calibrated magnitude smoother.
// ----------------------------------------------------------------------------
package acms_pkg;

  localparam int CAL_SAMPLES_DEF = 1024;
  localparam int RAW_W           = 16;
  localparam int OUT_W           = 27;
  localparam int WLEN_W          = 8;
  localparam int NUM_AXES        = 3;
  localparam int DIVISOR         = 5;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(30);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Calibration sample counter, able to hold the sample count itself.
  function automatic int cnt_w(input int cal);
    return $clog2(cal + 1);
  endfunction

  // Per-axis offset sum; the offset-free magnitude |raw*cal - sum| fits too.
  function automatic int sum_w(input int cal);
    return RAW_W + $clog2(cal);
  endfunction

  // Sum of three squares.
  function automatic int sq_w(input int cal);
    return 2 * sum_w(cal) + 2;
  endfunction

  // Square root result, also the number of root iterations.
  function automatic int mag_w(input int cal);
    return sum_w(cal) + 1;
  endfunction

  // Numerator 2*prev + 3*mag, rounded up to whole radix-4 digits.
  function automatic int dn_w(input int cal);
    int w;
    w = max_int(OUT_W + 1, mag_w(cal) + 2) + 1;
    return w + (w % 2);
  endfunction

  function automatic int div_iters(input int cal);
    return dn_w(cal) / 2;
  endfunction

  function automatic int step_w(input int cal);
    return $clog2(max_int(mag_w(cal), max_int(div_iters(cal), NUM_AXES)));
  endfunction

  typedef struct packed {
    logic       cal_acc;
    logic       load_in;
    logic       sq_step;
    logic [1:0] axis;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic calibrating;
    logic window_end;
  } sts_t;

endpackage

FILE: src/acms_dp.sv
// ----------------------------------------------------------------------------
// acms_dp
// Datapath: offset sums, squares on a shared multiplier, iterative square
// root, radix-4 divide by five, window state and the result register.
// ----------------------------------------------------------------------------
module acms_dp #(
  parameter int CAL_SAMPLES = acms_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acms_pkg::WLEN_W-1:0]         cfg_wdata,
  input  logic signed [acms_pkg::RAW_W-1:0]   in_raw_x,
  input  logic signed [acms_pkg::RAW_W-1:0]   in_raw_y,
  input  logic signed [acms_pkg::RAW_W-1:0]   in_raw_z,
  input  acms_pkg::cmd_t                      cmd,
  output acms_pkg::sts_t                      sts,
  output logic [acms_pkg::OUT_W-1:0]          out_smoothed_magnitude
);

  localparam int RAW_W  = acms_pkg::RAW_W;
  localparam int OUT_W  = acms_pkg::OUT_W;
  localparam int WLEN_W = acms_pkg::WLEN_W;
  localparam int CNT_W  = acms_pkg::cnt_w(CAL_SAMPLES);
  localparam int SUM_W  = acms_pkg::sum_w(CAL_SAMPLES);
  localparam int D_W    = SUM_W + 1;
  localparam int A_W    = SUM_W;
  localparam int SQ_W   = acms_pkg::sq_w(CAL_SAMPLES);
  localparam int MAG_W  = acms_pkg::mag_w(CAL_SAMPLES);
  localparam int DN_W   = acms_pkg::dn_w(CAL_SAMPLES);

  localparam logic signed [D_W-1:0] CAL_S    = D_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0]      CAL_CNT  = CNT_W'(CAL_SAMPLES);
  localparam logic [SQ_W-1:0]       BIT_TOP  = SQ_W'(1) << (SQ_W - 2);
  localparam logic [4:0]            DIV_X1   = 5'(acms_pkg::DIVISOR);
  localparam logic [4:0]            DIV_X2   = 5'(2 * acms_pkg::DIVISOR);
  localparam logic [4:0]            DIV_X3   = 5'(3 * acms_pkg::DIVISOR);

  // Window and calibration state.
  logic [WLEN_W-1:0]       wlen_r;
  logic [CNT_W-1:0]        cal_cnt_r;
  logic signed [SUM_W-1:0] sum_r [acms_pkg::NUM_AXES];
  logic [WLEN_W-1:0]       pos_r;
  logic [OUT_W-1:0]        smooth_r;

  // Working registers of one sample.
  logic [A_W-1:0]          abs_r [acms_pkg::NUM_AXES];
  logic [SQ_W-1:0]         acc_r;
  logic [SQ_W-1:0]         root_r;
  logic [SQ_W-1:0]         bit_r;
  logic [DN_W-1:0]         num_r;
  logic [DN_W-1:0]         quo_r;
  logic [2:0]              rmd_r;
  logic [OUT_W-1:0]        out_r;

  logic signed [RAW_W-1:0] raw_in [acms_pkg::NUM_AXES];
  logic signed [D_W-1:0]   diff   [acms_pkg::NUM_AXES];
  logic [A_W-1:0]          abs_nxt [acms_pkg::NUM_AXES];
  logic [A_W-1:0]          sq_sel;
  logic [2*A_W-1:0]        sq_prod;
  logic [SQ_W-1:0]         trial;
  logic [DN_W-1:0]         mag_ext;
  logic [DN_W-1:0]         num_init;
  logic [4:0]              part;
  logic [1:0]              digit;
  logic [2:0]              rmd_nxt;
  logic [WLEN_W:0]         len_eff;
  logic [WLEN_W:0]         pos_inc;

  assign raw_in[0] = in_raw_x;
  assign raw_in[1] = in_raw_y;
  assign raw_in[2] = in_raw_z;

  // Offset removal in units of one calibration sample fraction.
  always_comb begin
    for (int i = 0; i < acms_pkg::NUM_AXES; i++) begin
      diff[i]    = D_W'(raw_in[i]) * CAL_S - D_W'(sum_r[i]);
      abs_nxt[i] = diff[i][D_W-1] ? A_W'(-diff[i]) : A_W'(diff[i]);
    end
  end

  always_comb begin
    case (cmd.axis)
      acms_pkg::AXIS_X: sq_sel = abs_r[0];
      acms_pkg::AXIS_Y: sq_sel = abs_r[1];
      default:          sq_sel = abs_r[2];
    endcase
  end

  assign sq_prod = sq_sel * sq_sel;
  assign trial   = root_r + bit_r;

  assign mag_ext  = DN_W'(root_r[MAG_W-1:0]);
  assign num_init = (DN_W'(smooth_r) << 1) + (mag_ext << 1) + mag_ext;

  // One radix-4 quotient digit of the divide by five.
  always_comb begin
    part = {rmd_r, num_r[DN_W-1 -: 2]};
    if (part >= DIV_X3) begin
      digit   = 2'd3;
      rmd_nxt = 3'(part - DIV_X3);
    end else if (part >= DIV_X2) begin
      digit   = 2'd2;
      rmd_nxt = 3'(part - DIV_X2);
    end else if (part >= DIV_X1) begin
      digit   = 2'd1;
      rmd_nxt = 3'(part - DIV_X1);
    end else begin
      digit   = 2'd0;
      rmd_nxt = 3'(part);
    end
  end

  // A stored length of zero stands for 256 samples.
  assign len_eff = (wlen_r == '0) ? (WLEN_W+1)'(1 << WLEN_W) : {1'b0, wlen_r};
  assign pos_inc = {1'b0, pos_r} + (WLEN_W+1)'(1);

  assign sts.calibrating = (cal_cnt_r < CAL_CNT);
  assign sts.window_end  = (pos_inc >= len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= acms_pkg::WLEN_RESET;
      cal_cnt_r <= '0;
      pos_r     <= '0;
      smooth_r  <= '0;
      for (int i = 0; i < acms_pkg::NUM_AXES; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
      if (cmd.cal_acc) begin
        cal_cnt_r <= cal_cnt_r + CNT_W'(1);
        for (int i = 0; i < acms_pkg::NUM_AXES; i++) begin
          sum_r[i] <= sum_r[i] + SUM_W'(raw_in[i]);
        end
      end
      if (cmd.finish) begin
        if (sts.window_end) begin
          pos_r    <= '0;
          smooth_r <= '0;
        end else begin
          pos_r    <= pos_r + WLEN_W'(1);
          smooth_r <= quo_r[OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < acms_pkg::NUM_AXES; i++) begin
        abs_r[i] <= abs_nxt[i];
      end
      acc_r  <= '0;
      root_r <= '0;
      bit_r  <= BIT_TOP;
    end
    if (cmd.sq_step) begin
      acc_r <= acc_r + SQ_W'(sq_prod);
    end
    if (cmd.root_step) begin
      if (acc_r >= trial) begin
        acc_r  <= acc_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      num_r <= num_init;
      quo_r <= '0;
      rmd_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= num_r << 2;
      quo_r <= {quo_r[DN_W-3:0], digit};
      rmd_r <= rmd_nxt;
    end
    if (cmd.finish && sts.window_end) begin
      out_r <= quo_r[OUT_W-1:0];
    end
  end

  assign out_smoothed_magnitude = out_r;

endmodule

FILE: src/acms_ctrl.sv
// ----------------------------------------------------------------------------
// acms_ctrl
// Controller: sequences squares, root, divide and window update for one
// sample, and owns both channel handshakes.
// ----------------------------------------------------------------------------
`include "accel_calibrated_magnitude_smoother_unit_assert.svh"

module acms_ctrl #(
  parameter int CAL_SAMPLES = acms_pkg::CAL_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  acms_pkg::sts_t sts,
  output acms_pkg::cmd_t cmd
);

  localparam int STEP_W = acms_pkg::step_w(CAL_SAMPLES);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(acms_pkg::mag_w(CAL_SAMPLES) - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(acms_pkg::div_iters(CAL_SAMPLES) - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQ   = 6'b000010,
    ST_ROOT = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              root_last;
  logic              result_load;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        // No sample is taken while reset is held.
        in_stall = !rst_n;
        if (in_valid && !in_stall) begin
          if (sts.calibrating) begin
            cmd.cal_acc = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt   = ST_SQ;
            cnt_nxt     = '0;
          end
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.axis    = cnt_r[1:0];
        if (cnt_r[1:0] == acms_pkg::AXIS_Z) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_PREP;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_DONE: begin
        // A finished window waits only while an older result is still held.
        if (!sts.window_end || !out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          if (sts.window_end) begin
            out_valid_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assign root_last   = (state_r == ST_ROOT) && (cnt_r == ROOT_LAST);
  assign result_load = cmd.finish && sts.window_end;

  `ACMS_ASSERT_NXT(a_load_starts_squares, clk, rst_n, cmd.load_in, state_r == ST_SQ)
  `ACMS_ASSERT_NXT(a_root_runs_full, clk, rst_n, root_last, state_r == ST_PREP)
  `ACMS_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, result_load, !(out_valid_r && out_stall))
  `ACMS_ASSERT_NXT(a_window_end_shows, clk, rst_n, result_load, out_valid_r)

endmodule

FILE: src/accel_calibrated_magnitude_smoother_unit.sv
// ----------------------------------------------------------------------------
// accel_calibrated_magnitude_smoother_unit
// Offset-calibrated three-axis acceleration magnitude with windowed
// exponential smoothing.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the in_ channel (in_valid/in_stall); a sample transfers
// on a rising edge with in_valid high and in_stall low. After reset the
// first CAL_SAMPLES transfers only build the per-axis offset sums and
// produce no result. Every later sample passes, in order, through an
// accept step, three squares on the shared multiplier, the iterative
// square root with one step per root bit, a divide setup, the radix-4
// divide by five and a window update; in_stall stays high until the
// window update is done. The square root has the most steps.
// One result transfers on the out_ channel at the end of each window of
// cfg_wdata samples (a stored zero means 256), once the last sample of
// the window is done. A result waits in the output register while
// out_stall is high; the next sample is still taken and worked on, and only
// the next window end holds off until the old result has transferred.
// Synchronous reset (rst_n low) holds in_stall high, restarts calibration
// and sets the window length to 30. Write cfg_wdata with cfg_we while idle.
// ----------------------------------------------------------------------------
module accel_calibrated_magnitude_smoother_unit #(
  parameter int CAL_SAMPLES = acms_pkg::CAL_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [acms_pkg::WLEN_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [acms_pkg::RAW_W-1:0] in_raw_x,
  input  logic signed [acms_pkg::RAW_W-1:0] in_raw_y,
  input  logic signed [acms_pkg::RAW_W-1:0] in_raw_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [acms_pkg::OUT_W-1:0]        out_smoothed_magnitude
);

  // Commands from the controller and status back from the datapath.
  acms_pkg::cmd_t cmd;
  acms_pkg::sts_t sts;

  acms_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the offset sums, the window state and the result.
  acms_dp #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_raw_x               (in_raw_x),
    .in_raw_y               (in_raw_y),
    .in_raw_z               (in_raw_z),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_smoothed_magnitude (out_smoothed_magnitude)
  );

endmodule
